>>> hdl/tope_pkg.sv
// ----------------------------------------------------------------------------
// tope_pkg
// Shared types, codes and widths of the 2-opt tour engine.
// ----------------------------------------------------------------------------
package tope_pkg;

    localparam int DEF_MAX_CITIES = 256;
    localparam int DEF_DIST_BITS  = 32;

    localparam int KIND_W  = 3;
    localparam int INDEX_W = 8;
    localparam int CITY_W  = 8;
    localparam int CFG_W   = 9;
    localparam int DELTA_W = 34;
    localparam int LEN_W   = 40;
    localparam int VALUE_W = 32;

    localparam logic [KIND_W-1:0] KIND_DIST_WR = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TOUR_WR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELTA   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_APPLY   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LENGTH  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_REVERSE,
        ST_LENGTH,
        ST_FINISH,
        ST_RESPOND
    } state_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_SUB,
        ACC_ADD_SAT
    } acc_op_t;

    function automatic int acc_width(input int dist_bits);
        return (dist_bits + 3 > LEN_W + 2) ? dist_bits + 3 : LEN_W + 2;
    endfunction

endpackage

>>> hdl/tope_acc.sv
// ----------------------------------------------------------------------------
// tope_acc
// Shared accumulator: hold, clear, add, subtract, or add with length saturation.
// ----------------------------------------------------------------------------
module tope_acc import tope_pkg::*; #(
    parameter int DIST_BITS = DEF_DIST_BITS
) (
    input  logic                                  aclk,
    input  acc_op_t                               op,
    input  logic [DIST_BITS-1:0]                  operand,
    output logic signed [acc_width(DIST_BITS)-1:0] acc
);

    localparam int ACC_W = acc_width(DIST_BITS);
    localparam logic signed [ACC_W-1:0] LEN_SAT = {{(ACC_W-LEN_W){1'b0}}, {LEN_W{1'b1}}};

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] operand_ext;
    logic signed [ACC_W-1:0] sum;

    assign operand_ext = {{(ACC_W-DIST_BITS){1'b0}}, operand};
    assign sum         = acc_reg + operand_ext;

    always_comb begin
        case (op)
            ACC_CLEAR:   acc_next = '0;
            ACC_ADD:     acc_next = sum;
            ACC_SUB:     acc_next = acc_reg - operand_ext;
            ACC_ADD_SAT: acc_next = (sum > LEN_SAT) ? LEN_SAT : sum;
            default:     acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

>>> hdl/tope_dist_mem.sv
// ----------------------------------------------------------------------------
// tope_dist_mem
// Distance matrix storage, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tope_dist_mem import tope_pkg::*; #(
    parameter int MAX_CITIES = DEF_MAX_CITIES,
    parameter int DIST_BITS  = DEF_DIST_BITS
) (
    input  logic                                          aclk,
    input  logic                                          we,
    input  logic [$clog2(MAX_CITIES*MAX_CITIES)-1:0]      waddr,
    input  logic [DIST_BITS-1:0]                          wdata,
    input  logic [$clog2(MAX_CITIES*MAX_CITIES)-1:0]      raddr,
    output logic [DIST_BITS-1:0]                          rdata
);

    localparam int DEPTH = MAX_CITIES * MAX_CITIES;

    logic [DIST_BITS-1:0] mem [DEPTH];
    logic [DIST_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/tope_tour_mem.sv
// ----------------------------------------------------------------------------
// tope_tour_mem
// Tour storage, one city per position, one write and one registered read.
// ----------------------------------------------------------------------------
module tope_tour_mem import tope_pkg::*; #(
    parameter int MAX_CITIES = DEF_MAX_CITIES
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [$clog2(MAX_CITIES)-1:0] waddr,
    input  logic [CITY_W-1:0]             wdata,
    input  logic [$clog2(MAX_CITIES)-1:0] raddr,
    output logic [CITY_W-1:0]             rdata
);

    logic [CITY_W-1:0] mem [MAX_CITIES];
    logic [CITY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/two_opt_tour_engine_top.sv
// ----------------------------------------------------------------------------
// two_opt_tour_engine_top
// 2-opt engine for the symmetric TSP over a stored distance matrix and tour.
//
// Input channel s_*: one transaction per command (write distance, write tour
// position, move delta, apply move, tour length). Result channel m_*: exactly
// one transaction per command, carrying status, move delta and tour length.
// Configuration channel cfg_*: writes city_count; write it only while idle.
// The block takes one command at a time; s_ready is low while it works.
// Work per command, from input accept to m_valid:
//   writes, errors, unknown kinds: straight to the result
//   move delta: four tour reads, then four distance reads
//   apply move: steps swaps, steps = half the reversed span; one swap at a
//     time, set by the single read and single write port of the tour memory
//   tour length: one edge per cycle through tour and distance reads
// A result held by a stalled receiver keeps the block busy until taken.
// Reset sets city_count to 256 and clears control; both stores hold
// undefined contents until written.
// ----------------------------------------------------------------------------
module two_opt_tour_engine_top import tope_pkg::*; #(
    parameter int MAX_CITIES = DEF_MAX_CITIES,
    parameter int DIST_BITS  = DEF_DIST_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [KIND_W-1:0]         s_kind,
    input  logic [INDEX_W-1:0]        s_first_index,
    input  logic [INDEX_W-1:0]        s_second_index,
    input  logic [VALUE_W-1:0]        s_distance_value,
    input  logic [CITY_W-1:0]         s_city_id,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_status,
    output logic signed [DELTA_W-1:0] m_move_delta,
    output logic [LEN_W-1:0]          m_tour_length,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_W-1:0]          cfg_data
);

    localparam int PW    = $clog2(MAX_CITIES);
    localparam int NW    = $clog2(MAX_CITIES + 1);
    localparam int CW    = (NW > CFG_W) ? NW : CFG_W;
    localparam int DAW   = $clog2(MAX_CITIES * MAX_CITIES);
    localparam int ACC_W = acc_width(DIST_BITS);
    localparam int KW    = NW + 1;
    localparam logic signed [ACC_W-1:0] DELTA_SAT =
        {{(ACC_W-DELTA_W+1){1'b0}}, {(DELTA_W-1){1'b1}}};

    state_t state_reg, state_next;

    logic [CFG_W-1:0]         cfg_reg, cfg_next;
    logic [KW-1:0]            cnt_reg, cnt_next;
    logic [KIND_W-1:0]        kind_reg, kind_next;
    logic                     status_reg, status_next;
    logic [PW-1:0]            a_reg, a_next, b_reg, b_next;
    logic [PW-1:0]            i_reg, i_next, j_reg, j_next;
    logic [PW-1:0]            ip_reg, ip_next, jp_reg, jp_next;
    logic [NW-1:0]            steps_reg, steps_next;
    logic [CITY_W-1:0]        city_reg [4];
    logic [CITY_W-1:0]        city_next [4];
    logic [CITY_W-1:0]        prev_reg, prev_next, ti_reg, ti_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     m_status_reg, m_status_next;
    logic signed [DELTA_W-1:0] m_delta_reg, m_delta_next;
    logic [LEN_W-1:0]         m_len_reg, m_len_next;

    logic [CW-1:0]  n_cw;
    logic [NW-1:0]  n;
    logic [PW-1:0]  n_last;
    logic           a_ok, b_ok, city_ok, cmd_ok, accept;
    logic [CW:0]    span;
    logic [NW-1:0]  steps_calc;

    logic                 dist_we;
    logic [DAW-1:0]       dist_waddr, dist_raddr;
    logic [DIST_BITS-1:0] dist_rdata;
    logic [CITY_W-1:0]    dist_row, dist_col;
    logic                 tour_we;
    logic [PW-1:0]        tour_waddr, tour_raddr;
    logic [CITY_W-1:0]    tour_wdata, tour_rdata;
    acc_op_t              acc_op;
    logic signed [ACC_W-1:0] acc;

    function automatic logic [DAW-1:0] dist_addr(input logic [CITY_W-1:0] row,
                                                 input logic [CITY_W-1:0] col);
        return DAW'(PW'(row)) * DAW'(MAX_CITIES) + DAW'(PW'(col));
    endfunction

    function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p,
                                              input logic [PW-1:0] last);
        return (p == last) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] pos_dec(input logic [PW-1:0] p,
                                              input logic [PW-1:0] last);
        return (p == '0) ? last : p - 1'b1;
    endfunction

    // effective city count
    always_comb begin
        n_cw = CW'(cfg_reg);
        if (n_cw < CW'(2)) begin
            n_cw = CW'(2);
        end else if (n_cw > CW'(MAX_CITIES)) begin
            n_cw = CW'(MAX_CITIES);
        end
    end

    assign n       = NW'(n_cw);
    assign n_last  = PW'(n_cw - 1'b1);
    assign a_ok    = CW'(s_first_index) < n_cw;
    assign b_ok    = CW'(s_second_index) < n_cw;
    assign city_ok = CW'(s_city_id) < n_cw;
    assign accept  = s_valid && s_ready;

    always_comb begin
        case (s_kind)
            KIND_TOUR_WR: cmd_ok = a_ok && city_ok;
            KIND_DIST_WR, KIND_DELTA, KIND_APPLY: cmd_ok = a_ok && b_ok;
            default: cmd_ok = 1'b1;
        endcase
    end

    always_comb begin
        if (s_first_index < s_second_index) begin
            span = (CW+1)'(s_second_index) - (CW+1)'(s_first_index);
        end else begin
            span = (CW+1)'(n_cw) + (CW+1)'(s_second_index) - (CW+1)'(s_first_index);
        end
        steps_calc = NW'(span >> 1);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (cmd_ok && s_kind == KIND_DELTA) begin
                        state_next = ST_DELTA;
                    end else if (cmd_ok && s_kind == KIND_APPLY && steps_calc != '0) begin
                        state_next = ST_REVERSE;
                    end else if (s_kind == KIND_LENGTH) begin
                        state_next = ST_LENGTH;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DELTA: begin
                if (cnt_reg == KW'(9)) state_next = ST_FINISH;
            end
            ST_REVERSE: begin
                if (cnt_reg == {steps_reg, 1'b1}) state_next = ST_FINISH;
            end
            ST_LENGTH: begin
                if (cnt_reg == KW'(n) + KW'(2)) state_next = ST_FINISH;
            end
            ST_FINISH: state_next = ST_RESPOND;
            ST_RESPOND: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control and register updates
    always_comb begin
        cfg_next      = (cfg_valid && cfg_ready) ? cfg_data : cfg_reg;
        cnt_next      = (state_reg == ST_IDLE) ? '0 : cnt_reg + 1'b1;
        kind_next     = kind_reg;
        status_next   = status_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        ip_next       = ip_reg;
        jp_next       = jp_reg;
        steps_next    = steps_reg;
        city_next     = city_reg;
        prev_next     = tour_rdata;
        ti_next       = ti_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_delta_next  = m_delta_reg;
        m_len_next    = m_len_reg;

        dist_we    = 1'b0;
        dist_waddr = dist_addr(s_first_index, s_second_index);
        dist_row   = prev_reg;
        dist_col   = tour_rdata;
        tour_we    = 1'b0;
        tour_waddr = PW'(s_first_index);
        tour_wdata = s_city_id;
        tour_raddr = (cnt_reg == KW'(n)) ? '0 : PW'(cnt_reg);
        acc_op     = ACC_HOLD;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next   = s_kind;
                    status_next = !cmd_ok;
                    a_next      = PW'(s_first_index);
                    b_next      = PW'(s_second_index);
                    i_next      = PW'(s_first_index);
                    j_next      = pos_dec(PW'(s_second_index), n_last);
                    steps_next  = steps_calc;
                    acc_op      = ACC_CLEAR;
                    dist_we     = cmd_ok && s_kind == KIND_DIST_WR;
                    tour_we     = cmd_ok && s_kind == KIND_TOUR_WR;
                end
            end
            ST_DELTA: begin
                case (cnt_reg[3:0])
                    4'd0:    tour_raddr = a_reg;
                    4'd1:    tour_raddr = pos_dec(b_reg, n_last);
                    4'd2:    tour_raddr = pos_dec(a_reg, n_last);
                    default: tour_raddr = b_reg;
                endcase
                if (cnt_reg >= KW'(1) && cnt_reg <= KW'(4)) begin
                    city_next[2'(cnt_reg - 1'b1)] = tour_rdata;
                end
                case (cnt_reg[3:0])
                    4'd5: begin dist_row = city_reg[0]; dist_col = city_reg[2]; end
                    4'd6: begin dist_row = city_reg[1]; dist_col = city_reg[3]; end
                    4'd7: begin dist_row = city_reg[1]; dist_col = city_reg[2]; end
                    default: begin dist_row = city_reg[0]; dist_col = city_reg[3]; end
                endcase
                case (cnt_reg[3:0])
                    4'd6, 4'd7: acc_op = ACC_SUB;
                    4'd8, 4'd9: acc_op = ACC_ADD;
                    default:    acc_op = ACC_HOLD;
                endcase
            end
            ST_REVERSE: begin
                if (!cnt_reg[0]) begin
                    tour_raddr = i_reg;
                    tour_we    = cnt_reg != '0;
                    tour_waddr = ip_reg;
                    tour_wdata = tour_rdata;
                end else begin
                    tour_raddr = j_reg;
                    ti_next    = tour_rdata;
                    tour_we    = cnt_reg >= KW'(3);
                    tour_waddr = jp_reg;
                    tour_wdata = ti_reg;
                    ip_next    = i_reg;
                    jp_next    = j_reg;
                    i_next     = pos_inc(i_reg, n_last);
                    j_next     = pos_dec(j_reg, n_last);
                end
            end
            ST_LENGTH: begin
                if (cnt_reg >= KW'(3)) acc_op = ACC_ADD_SAT;
            end
            ST_FINISH: begin
                m_valid_next  = 1'b1;
                m_status_next = status_reg;
                m_delta_next  = '0;
                m_len_next    = '0;
                if (!status_reg && kind_reg == KIND_DELTA) begin
                    if (acc > DELTA_SAT) begin
                        m_delta_next = DELTA_W'(DELTA_SAT);
                    end else if (acc < -DELTA_SAT) begin
                        m_delta_next = DELTA_W'(-DELTA_SAT);
                    end else begin
                        m_delta_next = DELTA_W'(acc);
                    end
                end
                if (kind_reg == KIND_LENGTH) m_len_next = LEN_W'(acc);
            end
            ST_RESPOND: begin
                if (m_ready) m_valid_next = 1'b0;
            end
            default: ;
        endcase
        dist_raddr = dist_addr(dist_row, dist_col);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cfg_reg     <= CFG_W'(256);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        kind_reg     <= kind_next;
        status_reg   <= status_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        ip_reg       <= ip_next;
        jp_reg       <= jp_next;
        steps_reg    <= steps_next;
        city_reg     <= city_next;
        prev_reg     <= prev_next;
        ti_reg       <= ti_next;
        m_status_reg <= m_status_next;
        m_delta_reg  <= m_delta_next;
        m_len_reg    <= m_len_next;
    end

    tope_dist_mem #(
        .MAX_CITIES (MAX_CITIES),
        .DIST_BITS  (DIST_BITS)
    ) u_dist_mem (
        .aclk  (aclk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (DIST_BITS'(s_distance_value)),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    tope_tour_mem #(
        .MAX_CITIES (MAX_CITIES)
    ) u_tour_mem (
        .aclk  (aclk),
        .we    (tour_we),
        .waddr (tour_waddr),
        .wdata (tour_wdata),
        .raddr (tour_raddr),
        .rdata (tour_rdata)
    );

    tope_acc #(
        .DIST_BITS (DIST_BITS)
    ) u_acc (
        .aclk    (aclk),
        .op      (acc_op),
        .operand (dist_rdata),
        .acc     (acc)
    );

    assign s_ready       = state_reg == ST_IDLE;
    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_move_delta  = m_delta_reg;
    assign m_tour_length = m_len_reg;

endmodule

>>> sim/tb_two_opt_tour_engine_top.sv
// ----------------------------------------------------------------------------
// tb_two_opt_tour_engine_top
// Self-checking testbench for the 2-opt tour engine.
//
// Commands go in on the s_ channel and results are checked on the m_ channel
// against a scoreboard that keeps its own copy of the matrix, the tour and the
// city count. Before any command that reads the stores, the needed tour
// positions and distances are written first, so undefined entries are never
// read. The city count moves through several settings, both extremes too,
// and both channels stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
    logic [2:0]  kind;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [31:0] value;
    logic [7:0]  city;
} tour_cmd_t;

typedef struct {
    logic               status;
    logic signed [33:0] delta;
    logic [39:0]        length;
} tour_res_t;

class tour_scoreboard;
    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_RANGE = 1'b1;
    localparam longint DELTA_SAT = 64'h1_FFFF_FFFF;
    localparam longint LEN_SAT   = 64'hFF_FFFF_FFFF;

    logic [31:0] dist_val [65536];
    bit          dist_set [65536];
    logic [7:0]  tour [256];
    bit          tour_set [256];
    int          n = 256;
    tour_res_t   expected_q [$];
    int          errors = 0;

    function void set_count(logic [8:0] v);
        n = (v < 2) ? 2 : ((v > 256) ? 256 : int'(v));
    endfunction

    function longint dd(int r, int c);
        return longint'(dist_val[r * 256 + c]);
    endfunction

    function bit in_range(tour_cmd_t x);
        case (x.kind)
            tope_pkg::KIND_DIST_WR, tope_pkg::KIND_DELTA, tope_pkg::KIND_APPLY:
                return x.a < n && x.b < n;
            tope_pkg::KIND_TOUR_WR: return x.a < n && x.city < n;
            default: return 1;
        endcase
    endfunction

    // Find a write that has to come before x so no undefined entry is read.
    function bit fixup(tour_cmd_t x, output tour_cmd_t f);
        int p, c1, c2, c1p, c2n, k;
        int pr [$];
        f.kind = tope_pkg::KIND_TOUR_WR;
        f.a = 0; f.b = 0; f.value = $urandom; f.city = $urandom_range(0, n - 1);
        if (!(x.kind inside {tope_pkg::KIND_DELTA, tope_pkg::KIND_APPLY,
                             tope_pkg::KIND_LENGTH}) || !in_range(x))
            return 0;
        for (p = 0; p < n; p++)
            if (!tour_set[p]) begin
                f.a = p;
                return 1;
            end
        if (x.kind == tope_pkg::KIND_APPLY)
            return 0;
        if (x.kind == tope_pkg::KIND_DELTA) begin
            c1 = tour[x.a]; c2 = tour[(n + x.b - 1) % n];
            c1p = tour[(n + x.a - 1) % n]; c2n = tour[x.b];
            pr = '{c1, c1p, c2, c2n, c2, c1p, c1, c2n};
        end else begin
            for (p = 0; p < n; p++) begin
                pr.push_back(tour[p]);
                pr.push_back(tour[(p + 1) % n]);
            end
        end
        for (k = 0; k < pr.size(); k += 2)
            if (!dist_set[pr[k] * 256 + pr[k+1]]) begin
                if (pr[k] < n && pr[k+1] < n) begin
                    f.kind = tope_pkg::KIND_DIST_WR;
                    f.a = pr[k]; f.b = pr[k+1];
                end else begin
                    for (p = 0; p < n; p++)
                        if (tour[p] >= n) f.a = p;
                end
                return 1;
            end
        return 0;
    endfunction

    function void note(tour_cmd_t x);
        tour_res_t r;
        longint d, sum;
        int i, steps, c1, c2, c1p, c2n, pi, pj;
        logic [7:0] t;
        r.status = STAT_OK; r.delta = '0; r.length = '0;
        if (!in_range(x)) begin
            r.status = STAT_RANGE;
        end else begin
            case (x.kind)
                tope_pkg::KIND_DIST_WR: begin
                    dist_val[x.a * 256 + x.b] = x.value;
                    dist_set[x.a * 256 + x.b] = 1;
                end
                tope_pkg::KIND_TOUR_WR: begin
                    tour[x.a] = x.city;
                    tour_set[x.a] = 1;
                end
                tope_pkg::KIND_DELTA: begin
                    c1 = tour[x.a]; c2 = tour[(n + x.b - 1) % n];
                    c1p = tour[(n + x.a - 1) % n]; c2n = tour[x.b];
                    d = dd(c2, c1p) + dd(c1, c2n) - dd(c1, c1p) - dd(c2, c2n);
                    if (d > DELTA_SAT) d = DELTA_SAT;
                    if (d < -DELTA_SAT) d = -DELTA_SAT;
                    r.delta = d[33:0];
                end
                tope_pkg::KIND_APPLY: begin
                    steps = (x.a < x.b) ? (x.b - x.a) / 2 : (n - (x.a - x.b)) / 2;
                    for (i = 0; i < steps; i++) begin
                        pi = (x.a + i) % n;
                        pj = (n + x.b - 1 - i) % n;
                        t = tour[pi]; tour[pi] = tour[pj]; tour[pj] = t;
                    end
                end
                tope_pkg::KIND_LENGTH: begin
                    sum = 0;
                    for (i = 0; i < n; i++) begin
                        sum += dd(tour[i], tour[(i + 1) % n]);
                        if (sum > LEN_SAT) sum = LEN_SAT;
                    end
                    r.length = sum[39:0];
                end
                default: ;
            endcase
        end
        expected_q.push_back(r);
    endfunction

    function void check(tour_res_t got);
        tour_res_t e;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result status=%0d delta=%0d length=%0d",
                     $realtime, got.status, got.delta, got.length);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (got.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, e.status, got.status);
            errors++;
        end
        if (got.delta !== e.delta) begin
            $display("%0t: move_delta expected %0d actual %0d", $realtime, e.delta, got.delta);
            errors++;
        end
        if (got.length !== e.length) begin
            $display("%0t: tour_length expected %0d actual %0d",
                     $realtime, e.length, got.length);
            errors++;
        end
    endfunction
endclass

module tb_two_opt_tour_engine_top;
    import tope_pkg::*;

    localparam int STALL_MAX  = 16;
    localparam int IDLE_LIMIT = 20000;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [KIND_W-1:0]         s_kind = '0;
    logic [INDEX_W-1:0]        s_first_index = '0;
    logic [INDEX_W-1:0]        s_second_index = '0;
    logic [VALUE_W-1:0]        s_distance_value = '0;
    logic [CITY_W-1:0]         s_city_id = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_status;
    logic signed [DELTA_W-1:0] m_move_delta;
    logic [LEN_W-1:0]          m_tour_length;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_W-1:0]          cfg_data = '0;

    tour_scoreboard sb = new();
    bit             burst = 0;
    int             rx_stall = 0;
    int             idle_cycles = 0;

    two_opt_tour_engine_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_first_index    (s_first_index),
        .s_second_index   (s_second_index),
        .s_distance_value (s_distance_value),
        .s_city_id        (s_city_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_move_delta     (m_move_delta),
        .m_tour_length    (m_tour_length),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, STALL_MAX);
    endfunction

    always @(posedge aclk) begin
        tour_res_t r;
        int draw;
        if (aresetn && m_valid && m_ready) begin
            r.status = m_status; r.delta = m_move_delta; r.length = m_tour_length;
            sb.check(r);
            draw = draw_gap();
            rx_stall <= draw;
            m_ready <= (draw == 0);
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_ready <= (rx_stall == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_cmd(tour_cmd_t x);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_kind           <= x.kind;
        s_first_index    <= x.a;
        s_second_index   <= x.b;
        s_distance_value <= x.value;
        s_city_id        <= x.city;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note(x);
    endtask

    task automatic issue(tour_cmd_t x);
        tour_cmd_t f;
        while (sb.fixup(x, f)) push_cmd(f);
        push_cmd(x);
    endtask

    task automatic cmd(logic [2:0] k, int a, int b, logic [31:0] v, int c);
        tour_cmd_t x;
        x.kind = k; x.a = a; x.b = b; x.value = v; x.city = c;
        issue(x);
    endtask

    task automatic write_count(logic [8:0] v);
        s_valid <= 1'b0;
        while (sb.expected_q.size() > 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_count(v);
    endtask

    function automatic tour_cmd_t rand_cmd(bit reads_ok);
        tour_cmd_t x;
        int sel, n;
        n = sb.n;
        x.a = $urandom_range(0, n - 1);
        x.b = $urandom_range(0, n - 1);
        x.value = $urandom;
        x.city = $urandom_range(0, n - 1);
        sel = $urandom_range(0, 99);
        if (sel < 15)       x.kind = KIND_DIST_WR;
        else if (sel < 30)  x.kind = KIND_TOUR_WR;
        else if (sel < 55)  x.kind = reads_ok ? KIND_DELTA : KIND_DIST_WR;
        else if (sel < 80)  x.kind = reads_ok ? KIND_APPLY : KIND_TOUR_WR;
        else if (sel < 88)  x.kind = reads_ok ? KIND_LENGTH : KIND_DIST_WR;
        else if (sel < 95)  x.kind = $urandom_range(KIND_DIST_WR, KIND_APPLY);
        else                x.kind = $urandom_range(KIND_LENGTH + 1, 7);
        if (sel >= 88 && sel < 95 && n < 256) begin
            case ($urandom_range(0, 2))
                0: x.a = $urandom_range(n, 255);
                1: x.b = $urandom_range(n, 255);
                default: x.city = $urandom_range(n, 255);
            endcase
        end
        return x;
    endfunction

    initial begin
        logic [8:0] counts [$];
        int i, j;
        counts = '{9'd5, 9'd1, 9'd9, 9'd300, 9'd16, 9'd3, 9'd12, 9'd256, 9'd7, 9'd4, 9'd24};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full-size matrix: extremes of the fields, unknown kinds
        cmd(KIND_DIST_WR, 255, 255, 32'hFFFF_FFFF, 0);
        cmd(KIND_DIST_WR, 0, 128, 32'h0, 0);
        cmd(KIND_TOUR_WR, 255, 0, 0, 255);
        cmd(KIND_TOUR_WR, 128, 0, 0, 0);
        cmd(KIND_LENGTH + 1, 255, 255, 32'hFFFF_FFFF, 255);
        cmd(3'd7, 0, 0, 0, 0);

        // smallest tour: range errors, equal and wrapping moves
        write_count(9'd0);
        cmd(KIND_DIST_WR, 2, 0, 1, 0);
        cmd(KIND_DIST_WR, 0, 255, 1, 0);
        cmd(KIND_TOUR_WR, 1, 0, 0, 2);
        cmd(KIND_TOUR_WR, 2, 0, 0, 1);
        cmd(KIND_DELTA, 0, 5, 0, 0);
        cmd(KIND_APPLY, 3, 0, 0, 0);
        cmd(KIND_LENGTH, 0, 0, 0, 0);
        cmd(KIND_DELTA, 1, 0, 0, 0);
        cmd(KIND_APPLY, 1, 1, 0, 0);
        cmd(KIND_APPLY, 1, 0, 0, 0);
        cmd(KIND_LENGTH, 0, 0, 0, 0);

        write_count(9'd6);
        cmd(KIND_DIST_WR, 5, 4, 32'hFFFF_FFFF, 0);
        cmd(KIND_DIST_WR, 4, 5, 32'hFFFF_FFFF, 0);
        cmd(KIND_DELTA, 5, 1, 0, 0);
        cmd(KIND_APPLY, 0, 5, 0, 0);
        cmd(KIND_APPLY, 4, 2, 0, 0);
        cmd(KIND_LENGTH, 0, 0, 0, 0);

        for (i = 0; i < counts.size(); i++) begin
            write_count(counts[i]);
            burst = ($urandom_range(0, 3) == 0);
            for (j = 0; j < ((sb.n > 64) ? 20 : 65); j++)
                issue(rand_cmd(sb.n <= 64));
        end

        write_count(9'd511);
        for (j = 0; j < 20; j++) issue(rand_cmd(0));
        write_count(9'd8);
        burst = 0;
        for (j = 0; j < 40; j++) issue(rand_cmd(1));

        s_valid <= 1'b0;
        while (sb.expected_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
